FILE: rtl/core/dcsfm_pkg.sv
// dcsfm_pkg: operation codes, control-word masks and interrupt bit positions
// for the dual-cpu mailbox; no dependencies
`default_nettype none

package dcsfm_pkg;

    // bus operation codes
    localparam logic [2:0] OP_WR_SYNC = 3'd0;
    localparam logic [2:0] OP_WR_CTRL = 3'd1;
    localparam logic [2:0] OP_RD_SYNC = 3'd2;
    localparam logic [2:0] OP_RD_CTRL = 3'd3;
    localparam logic [2:0] OP_SEND    = 3'd4;
    localparam logic [2:0] OP_RECV    = 3'd5;

    // control word masks
    localparam logic [15:0] CTRL_KEEP_MASK  = 16'h0303;
    localparam logic [15:0] CTRL_WR_BLOCK   = 16'h430B;
    localparam logic [15:0] SYNC_OWN_MASK   = 16'hFFF0;

    // control word bit positions
    localparam int unsigned CB_SEND_EMPTY    = 0;
    localparam int unsigned CB_PARTNER_RECV  = 1;
    localparam int unsigned CB_SE_IRQ_EN     = 2;
    localparam int unsigned CB_SET_SE        = 3;
    localparam int unsigned CB_RECV_EMPTY    = 8;
    localparam int unsigned CB_RNE_IRQ_EN    = 10;
    localparam int unsigned SB_PARTNER_IRQ   = 14;

    // interrupt request vector
    typedef logic [2:0] t_irq;
    localparam int unsigned IRQ_SYNC       = 0;
    localparam int unsigned IRQ_SEND_EMPTY = 1;
    localparam int unsigned IRQ_RECV_NE    = 2;

endpackage

`default_nettype wire

FILE: rtl/core/dual_cpu_sync_and_fifo_mailbox.sv
// dual_cpu_sync_and_fifo_mailbox: two-cpu mailbox with sync/control words and
// one receive fifo per side held in a single synchronous ram; uses dcsfm_pkg
//
//  channel | direction | handshake              | words
//  --------+-----------+------------------------+------------------------------
//  in      | to block  | i_in_valid / o_in_stall | i_side, i_op, i_wdata
//  out     | from block| o_out_valid / i_out_stall | o_rdata, o_irq_first, o_irq_second
//
// every access but a receive from a non-empty fifo loads the output register as
// it is taken; such a receive first waits in ST_READ for the registered fifo ram read.
// the result sits in an output register; a new word is taken when no receive waits
// in ST_READ and that register is empty or its result is drained in the same cycle.
// synchronous active-low reset clears all words, counts and pointers; fifo
// ram contents are left as they are and only read after being written.
`default_nettype none

module dual_cpu_sync_and_fifo_mailbox
    import dcsfm_pkg::*;
#(
    parameter int unsigned FIFO_DEPTH = 16
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_stall,
    input  wire logic        i_side,
    input  wire logic [2:0]  i_op,
    input  wire logic [31:0] i_wdata,
    output logic             o_out_valid,
    input  wire logic        i_out_stall,
    output logic [31:0]      o_rdata,
    output logic [2:0]       o_irq_first,
    output logic [2:0]       o_irq_second
);

    localparam int unsigned PW        = $clog2(FIFO_DEPTH);
    localparam int unsigned CW        = $clog2(FIFO_DEPTH + 1);
    localparam int unsigned MEM_WORDS = 2 * (1 << PW);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_READ = 1'b1;

    // per-side state
    logic [15:0]   r_ctrl_first, r_ctrl_second, n_ctrl_first, n_ctrl_second;
    logic [15:0]   r_sync_first, r_sync_second, n_sync_first, n_sync_second;
    logic [CW-1:0] r_cnt_first, r_cnt_second, n_cnt_first, n_cnt_second;
    logic [PW-1:0] r_rd_first, r_rd_second, n_rd_first, n_rd_second;

    // sequencer and output register
    logic          r_state, n_state;
    logic          r_out_valid;
    logic [31:0]   r_rdata;
    t_irq          r_irq_first, r_irq_second;
    t_irq          r_pend_first, r_pend_second;

    // fifo ram
    logic [31:0]   r_mem [0:MEM_WORDS-1];
    logic [31:0]   r_mem_q;
    logic          mem_we, mem_re;
    logic [PW:0]   mem_waddr, mem_raddr;

    // own / partner views
    logic [15:0]   own_ctrl, part_ctrl, own_sync, part_sync;
    logic [15:0]   n_own_ctrl, n_part_ctrl, n_own_sync;
    logic [CW-1:0] own_cnt, part_cnt, n_own_cnt, n_part_cnt;
    logic [PW-1:0] own_rd, part_rd, n_own_rd;
    logic [PW:0]   wr_sum;
    logic [PW-1:0] wr_idx;
    logic [15:0]   ctrl_tmp;
    t_irq          irq_own, irq_part, irq_first, irq_second;
    logic [31:0]   res_rdata;
    logic          out_free, accept, read_pending;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign o_in_stall = (r_state == ST_READ) || !out_free;
    assign accept     = i_in_valid && !o_in_stall;

    // side selection
    always_comb begin
        own_ctrl  = i_side ? r_ctrl_second : r_ctrl_first;
        part_ctrl = i_side ? r_ctrl_first  : r_ctrl_second;
        own_sync  = i_side ? r_sync_second : r_sync_first;
        part_sync = i_side ? r_sync_first  : r_sync_second;
        own_cnt   = i_side ? r_cnt_second  : r_cnt_first;
        part_cnt  = i_side ? r_cnt_first   : r_cnt_second;
        own_rd    = i_side ? r_rd_second   : r_rd_first;
        part_rd   = i_side ? r_rd_first    : r_rd_second;
    end

    // ring write slot in the partner fifo
    always_comb begin
        wr_sum = {1'b0, part_rd} + {1'b0, part_cnt[PW-1:0]};
        if (wr_sum >= (PW+1)'(FIFO_DEPTH)) begin
            wr_idx = PW'(wr_sum - (PW+1)'(FIFO_DEPTH));
        end else begin
            wr_idx = wr_sum[PW-1:0];
        end
    end

    // operation decode and state update
    always_comb begin
        n_own_ctrl   = own_ctrl;
        n_part_ctrl  = part_ctrl;
        n_own_sync   = own_sync;
        n_own_cnt    = own_cnt;
        n_part_cnt   = part_cnt;
        n_own_rd     = own_rd;
        ctrl_tmp     = own_ctrl;
        irq_own      = '0;
        irq_part     = '0;
        res_rdata    = '0;
        mem_we       = 1'b0;
        mem_re       = 1'b0;
        mem_waddr    = {~i_side, wr_idx};
        mem_raddr    = {i_side, own_rd};
        read_pending = 1'b0;
        case (i_op)
            OP_WR_SYNC: begin
                n_own_sync = i_wdata[15:0];
                irq_part[IRQ_SYNC] = i_wdata[SB_PARTNER_IRQ];
            end
            OP_WR_CTRL: begin
                if (i_wdata[CB_SET_SE]) begin
                    ctrl_tmp[CB_SEND_EMPTY] = 1'b1;
                end
                ctrl_tmp = (ctrl_tmp & CTRL_KEEP_MASK) | (i_wdata[15:0] & ~CTRL_WR_BLOCK);
                if (i_wdata[CB_SE_IRQ_EN] && own_cnt == '0) begin
                    ctrl_tmp[CB_SEND_EMPTY] = 1'b1;
                    irq_own[IRQ_SEND_EMPTY] = 1'b1;
                end
                n_own_ctrl = ctrl_tmp;
            end
            OP_RD_SYNC: begin
                res_rdata = {16'h0000, (own_sync & SYNC_OWN_MASK) | {12'h000, part_sync[11:8]}};
            end
            OP_RD_CTRL: begin
                res_rdata = {16'h0000, own_ctrl};
            end
            OP_SEND: begin
                if (part_cnt < CW'(FIFO_DEPTH)) begin
                    n_part_ctrl[CB_RECV_EMPTY] = 1'b0;
                    mem_we     = 1'b1;
                    n_part_cnt = part_cnt + CW'(1);
                    n_own_ctrl[CB_SEND_EMPTY] = 1'b0;
                    irq_part[IRQ_RECV_NE] = part_ctrl[CB_RNE_IRQ_EN];
                end
            end
            OP_RECV: begin
                if (own_cnt != '0) begin
                    mem_re       = 1'b1;
                    read_pending = 1'b1;
                    if (own_rd == PW'(FIFO_DEPTH - 1)) begin
                        n_own_rd = '0;
                    end else begin
                        n_own_rd = own_rd + PW'(1);
                    end
                    n_own_cnt = own_cnt - CW'(1);
                    if (own_cnt == CW'(1)) begin
                        n_own_ctrl[CB_RECV_EMPTY]  = 1'b1;
                        n_part_ctrl[CB_SEND_EMPTY] = 1'b1;
                        irq_own[IRQ_SEND_EMPTY]    = own_ctrl[CB_SE_IRQ_EN];
                    end
                    n_part_ctrl[CB_PARTNER_RECV] = 1'b0;
                end
            end
            default: begin
            end
        endcase
        // a gated access changes nothing
        if (!accept) begin
            mem_we       = 1'b0;
            mem_re       = 1'b0;
            read_pending = 1'b0;
        end
    end

    // map back to first / second
    always_comb begin
        irq_first     = i_side ? irq_part : irq_own;
        irq_second    = i_side ? irq_own  : irq_part;
        n_ctrl_first  = r_ctrl_first;
        n_ctrl_second = r_ctrl_second;
        n_sync_first  = r_sync_first;
        n_sync_second = r_sync_second;
        n_cnt_first   = r_cnt_first;
        n_cnt_second  = r_cnt_second;
        n_rd_first    = r_rd_first;
        n_rd_second   = r_rd_second;
        if (accept) begin
            if (i_side) begin
                n_ctrl_second = n_own_ctrl;
                n_ctrl_first  = n_part_ctrl;
                n_sync_second = n_own_sync;
                n_cnt_second  = n_own_cnt;
                n_cnt_first   = n_part_cnt;
                n_rd_second   = n_own_rd;
            end else begin
                n_ctrl_first  = n_own_ctrl;
                n_ctrl_second = n_part_ctrl;
                n_sync_first  = n_own_sync;
                n_cnt_first   = n_own_cnt;
                n_cnt_second  = n_part_cnt;
                n_rd_first    = n_own_rd;
            end
        end
    end

    // sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (read_pending) begin
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                if (out_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // fifo ram, one write and one registered read port
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= i_wdata;
        end
        if (mem_re) begin
            r_mem_q <= r_mem[mem_raddr];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctrl_first  <= '0;
            r_ctrl_second <= '0;
            r_sync_first  <= '0;
            r_sync_second <= '0;
            r_cnt_first   <= '0;
            r_cnt_second  <= '0;
            r_rd_first    <= '0;
            r_rd_second   <= '0;
            r_state       <= ST_IDLE;
            r_out_valid   <= 1'b0;
        end else begin
            r_ctrl_first  <= n_ctrl_first;
            r_ctrl_second <= n_ctrl_second;
            r_sync_first  <= n_sync_first;
            r_sync_second <= n_sync_second;
            r_cnt_first   <= n_cnt_first;
            r_cnt_second  <= n_cnt_second;
            r_rd_first    <= n_rd_first;
            r_rd_second   <= n_rd_second;
            r_state       <= n_state;
            if (accept && !read_pending) begin
                r_out_valid <= 1'b1;
            end else if (r_state == ST_READ && out_free) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result words and held irqs of a pending receive
    always_ff @(posedge i_clk) begin
        if (accept && !read_pending) begin
            r_rdata      <= res_rdata;
            r_irq_first  <= irq_first;
            r_irq_second <= irq_second;
        end else if (r_state == ST_READ && out_free) begin
            r_rdata      <= r_mem_q;
            r_irq_first  <= r_pend_first;
            r_irq_second <= r_pend_second;
        end
        if (read_pending) begin
            r_pend_first  <= irq_first;
            r_pend_second <= irq_second;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_rdata      = r_rdata;
    assign o_irq_first  = r_irq_first;
    assign o_irq_second = r_irq_second;

endmodule

`default_nettype wire

FILE: dv/dual_cpu_sync_and_fifo_mailbox_test.sv
// dual_cpu_sync_and_fifo_mailbox_test: self-checking bench for the two-cpu mailbox,
// with a directed opening, random access sequences, bursty sender and stalling receiver
// depends on dcsfm_pkg and dual_cpu_sync_and_fifo_mailbox
`timescale 1ns / 100ps

module dual_cpu_sync_and_fifo_mailbox_test;
    import dcsfm_pkg::*;

    localparam int unsigned MBOX_DEPTH   = 16;
    localparam int unsigned RANDOM_WORDS = 800;
    localparam int unsigned CYCLE_LIMIT  = 200000;
    localparam int unsigned DRAIN_CYCLES = 10;

    // op codes the block leaves unused
    localparam logic [2:0] OP_SPARE_6 = 3'd6;
    localparam logic [2:0] OP_SPARE_7 = 3'd7;

    typedef struct packed {
        logic        side;
        logic [2:0]  op;
        logic [31:0] wdata;
        logic        hold;
    } t_bus_word;

    typedef struct packed {
        logic [31:0] rdata;
        t_irq        irq_first;
        t_irq        irq_second;
    } t_mbox_result;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_in_valid = 1'b0;
    logic        i_side = 1'b0;
    logic [2:0]  i_op = OP_WR_SYNC;
    logic [31:0] i_wdata = 32'h0;
    logic        i_out_stall = 1'b0;
    logic        o_in_stall;
    logic        o_out_valid;
    logic [31:0] o_rdata;
    logic [2:0]  o_irq_first;
    logic [2:0]  o_irq_second;

    dual_cpu_sync_and_fifo_mailbox #(
        .FIFO_DEPTH(MBOX_DEPTH)
    ) u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_side      (i_side),
        .i_op        (i_op),
        .i_wdata     (i_wdata),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_rdata     (o_rdata),
        .o_irq_first (o_irq_first),
        .o_irq_second(o_irq_second)
    );

    // clock
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // mailbox state as the bus sees it
    logic [15:0] ctrl_word [2];
    logic [15:0] sync_word [2];
    logic [31:0] rx_fifo [2][MBOX_DEPTH];
    int unsigned rx_count [2];
    int unsigned rx_head [2];

    t_bus_word    word_queue [$];
    t_mbox_result result_queue [$];
    bit           hold_next;
    int unsigned  words_made;
    int           in_flight;
    int unsigned  burst_left;
    int unsigned  gap_left;
    int unsigned  fault_count;
    int unsigned  cycle_count;
    int unsigned  op_seen [8];
    int unsigned  full_drops;
    int unsigned  empty_pops;
    int unsigned  irq_words;

    // apply one bus access to the mailbox state and return what it should produce
    function automatic t_mbox_result mailbox_access(t_bus_word w);
        int unsigned  own;
        int unsigned  peer;
        logic [15:0]  c;
        t_irq         irq_to [2];
        t_mbox_result r;
        own = {31'b0, w.side};
        peer = own ^ 1;
        irq_to[0] = '0;
        irq_to[1] = '0;
        r.rdata = '0;
        op_seen[w.op]++;
        case (w.op)
            OP_WR_SYNC: begin
                sync_word[own] = w.wdata[15:0];
                if (sync_word[own][SB_PARTNER_IRQ])
                    irq_to[peer][IRQ_SYNC] = 1'b1;
            end
            OP_WR_CTRL: begin
                c = ctrl_word[own];
                if (w.wdata[CB_SET_SE])
                    c[CB_SEND_EMPTY] = 1'b1;
                c = (c & CTRL_KEEP_MASK) | (w.wdata[15:0] & ~CTRL_WR_BLOCK);
                if (w.wdata[CB_SE_IRQ_EN] && rx_count[own] == 0) begin
                    c[CB_SEND_EMPTY] = 1'b1;
                    irq_to[own][IRQ_SEND_EMPTY] = 1'b1;
                end
                ctrl_word[own] = c;
            end
            OP_RD_SYNC: begin
                r.rdata = {16'h0, (sync_word[own] & SYNC_OWN_MASK) |
                                  {12'h0, sync_word[peer][11:8]}};
            end
            OP_RD_CTRL: begin
                r.rdata = {16'h0, ctrl_word[own]};
            end
            OP_SEND: begin
                if (rx_count[peer] < MBOX_DEPTH) begin
                    ctrl_word[peer][CB_RECV_EMPTY] = 1'b0;
                    rx_fifo[peer][(rx_head[peer] + rx_count[peer]) % MBOX_DEPTH] = w.wdata;
                    rx_count[peer]++;
                    ctrl_word[own][CB_SEND_EMPTY] = 1'b0;
                    if (ctrl_word[peer][CB_RNE_IRQ_EN])
                        irq_to[peer][IRQ_RECV_NE] = 1'b1;
                end else begin
                    full_drops++;
                end
            end
            OP_RECV: begin
                if (rx_count[own] != 0) begin
                    r.rdata = rx_fifo[own][rx_head[own]];
                    rx_head[own] = (rx_head[own] + 1) % MBOX_DEPTH;
                    rx_count[own]--;
                    if (rx_count[own] == 0) begin
                        ctrl_word[own][CB_RECV_EMPTY] = 1'b1;
                        ctrl_word[peer][CB_SEND_EMPTY] = 1'b1;
                        if (ctrl_word[own][CB_SE_IRQ_EN])
                            irq_to[own][IRQ_SEND_EMPTY] = 1'b1;
                    end
                    ctrl_word[peer][CB_PARTNER_RECV] = 1'b0;
                end else begin
                    empty_pops++;
                end
            end
            default: begin
            end
        endcase
        r.irq_first = irq_to[0];
        r.irq_second = irq_to[1];
        if (irq_to[0] != 0 || irq_to[1] != 0)
            irq_words++;
        return r;
    endfunction

    // queue one bus word for the driver
    task automatic put(input logic side, input logic [2:0] op, input logic [31:0] data);
        t_bus_word w;
        w.side = side;
        w.op = op;
        w.wdata = data;
        w.hold = hold_next;
        hold_next = 1'b0;
        word_queue.push_back(w);
        words_made++;
    endtask

    // data mix: corners, single bits and plain random
    function automatic logic [31:0] pick_data();
        case ($urandom_range(0, 5))
            0: return 32'h0;
            1: return 32'hFFFF_FFFF;
            2: return 32'h1 << $urandom_range(0, 31);
            default: return $urandom;
        endcase
    endfunction

    // sender: bursts of words with random gaps, optional hold until drained
    always @(posedge i_clk) begin
        t_bus_word taken;
        t_bus_word nxt;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                taken.side = i_side;
                taken.op = i_op;
                taken.wdata = i_wdata;
                taken.hold = 1'b0;
                result_queue.push_back(mailbox_access(taken));
                in_flight++;
            end
            if (o_out_valid && !i_out_stall)
                in_flight--;
            if (!i_in_valid || !o_in_stall) begin
                if (gap_left > 0) begin
                    gap_left--;
                    i_in_valid <= 1'b0;
                end else if (word_queue.size() > 0 && !(word_queue[0].hold && in_flight > 0)) begin
                    nxt = word_queue.pop_front();
                    i_side <= nxt.side;
                    i_op <= nxt.op;
                    i_wdata <= nxt.wdata;
                    i_in_valid <= 1'b1;
                    if (burst_left > 1) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 24);
                        case ($urandom_range(0, 7))
                            0, 1: gap_left = 0;
                            2: gap_left = $urandom_range(10, 25);
                            default: gap_left = $urandom_range(1, 5);
                        endcase
                    end
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    // receiver stall pattern: free, random, long runs or alternating
    int unsigned stall_mode;
    int unsigned stall_mode_left;
    int unsigned stall_run;
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (stall_mode_left == 0) begin
                stall_mode = $urandom_range(0, 3);
                stall_mode_left = $urandom_range(20, 150);
            end else begin
                stall_mode_left--;
            end
            case (stall_mode)
                0: i_out_stall <= 1'b0;
                1: i_out_stall <= ($urandom_range(0, 2) == 0);
                2: begin
                    if (stall_run > 0) begin
                        stall_run--;
                        i_out_stall <= 1'b1;
                    end else begin
                        if ($urandom_range(0, 7) == 0)
                            stall_run = $urandom_range(2, 8);
                        i_out_stall <= 1'b0;
                    end
                end
                default: i_out_stall <= ~i_out_stall;
            endcase
        end
    end

    // result checker
    always @(posedge i_clk) begin
        t_mbox_result due;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (result_queue.size() == 0) begin
                $error("result word with nothing expected: rdata %h irq_first %b irq_second %b",
                       o_rdata, o_irq_first, o_irq_second);
                fault_count++;
            end else begin
                due = result_queue.pop_front();
                if (o_rdata !== due.rdata) begin
                    $error("rdata: expected %h, got %h", due.rdata, o_rdata);
                    fault_count++;
                end
                if (o_irq_first !== due.irq_first) begin
                    $error("irq_first: expected %b, got %b", due.irq_first, o_irq_first);
                    fault_count++;
                end
                if (o_irq_second !== due.irq_second) begin
                    $error("irq_second: expected %b, got %b", due.irq_second, o_irq_second);
                    fault_count++;
                end
            end
        end
    end

    // watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("dual_cpu_sync_and_fifo_mailbox test failed");
            $finish;
        end
    end

    // stimulus, reset and end of run
    initial begin
        int unsigned n;
        logic        s;
        for (int i = 0; i < 2; i++) begin
            ctrl_word[i] = '0;
            sync_word[i] = '0;
            rx_count[i] = 0;
            rx_head[i] = 0;
        end
        burst_left = 4;

        // directed opening: reset values, sync corners, control corners, fifo cases
        put(1'b0, OP_RD_CTRL, 32'h0);
        put(1'b1, OP_RD_SYNC, 32'h0);
        put(1'b0, OP_RECV, 32'hFFFF_FFFF);
        put(1'b0, OP_WR_SYNC, 32'hFFFF_FFFF);
        put(1'b1, OP_WR_SYNC, 32'h0000_4A00);
        put(1'b0, OP_RD_SYNC, 32'h0);
        put(1'b1, OP_RD_SYNC, 32'h0);
        put(1'b0, OP_WR_SYNC, 32'h0);
        put(1'b0, OP_WR_CTRL, 32'hFFFF_FFFF);
        put(1'b0, OP_RD_CTRL, 32'h0);
        put(1'b1, OP_WR_CTRL, 32'h0000_0408);
        put(1'b0, OP_SEND, 32'hFFFF_FFFF);
        put(1'b0, OP_SEND, 32'h0);
        put(1'b1, OP_WR_CTRL, 32'h0000_0004);
        put(1'b1, OP_RECV, 32'h0);
        put(1'b1, OP_RECV, 32'h0);
        put(1'b1, OP_RECV, 32'h0);
        put(1'b0, OP_RD_CTRL, 32'h0);
        put(1'b1, OP_RD_CTRL, 32'h0);
        put(1'b0, OP_SPARE_6, 32'hFFFF_FFFF);
        put(1'b1, OP_SPARE_7, 32'hFFFF_FFFF);
        put(1'b0, OP_WR_CTRL, 32'h0);
        put(1'b1, OP_WR_CTRL, 32'h0);

        // random sequences, mostly meaningful fifo and sync traffic
        hold_next = 1'b1;
        n = words_made + RANDOM_WORDS;
        while (words_made < n) begin
            s = 1'($urandom_range(0, 1));
            if ($urandom_range(0, 14) == 0)
                hold_next = 1'b1;
            case ($urandom_range(0, 9))
                0, 1: put(s, 3'($urandom_range(0, 7)), pick_data());
                2, 3: begin
                    // fill towards or past full, then drain from the other side
                    repeat ($urandom_range(1, MBOX_DEPTH + 3)) put(s, OP_SEND, pick_data());
                    repeat ($urandom_range(0, MBOX_DEPTH + 2)) begin
                        if ($urandom_range(0, 7) == 0)
                            put(1'($urandom_range(0, 1)), 3'($urandom_range(0, 7)),
                                pick_data());
                        put(~s, OP_RECV, pick_data());
                    end
                end
                4: begin
                    put(s, OP_WR_CTRL, pick_data() |
                        ($urandom_range(0, 1) << CB_SE_IRQ_EN) |
                        ($urandom_range(0, 1) << CB_RNE_IRQ_EN) |
                        ($urandom_range(0, 1) << CB_SET_SE));
                    put(s, OP_RD_CTRL, pick_data());
                end
                5: begin
                    put(s, OP_WR_SYNC, pick_data() | ($urandom_range(0, 1) << SB_PARTNER_IRQ));
                    put(~s, OP_RD_SYNC, pick_data());
                    put(s, OP_RD_SYNC, pick_data());
                end
                6, 7: begin
                    // ping-pong traffic
                    repeat ($urandom_range(1, 8)) begin
                        put(s, OP_SEND, pick_data());
                        if ($urandom_range(0, 3) == 0)
                            put(~s, OP_RD_CTRL, 32'h0);
                        put(~s, OP_RECV, pick_data());
                    end
                end
                8: begin
                    put(s, OP_RD_CTRL, pick_data());
                    put(~s, OP_RD_CTRL, pick_data());
                    put(s, OP_RD_SYNC, pick_data());
                end
                default: begin
                    put(s, OP_RECV, pick_data());
                    put(s, $urandom_range(0, 1) ? OP_SPARE_6 : OP_SPARE_7, pick_data());
                end
            endcase
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (word_queue.size() != 0 || i_in_valid || in_flight > 0)
            @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);

        if (result_queue.size() != 0) begin
            $error("%0d expected result words never arrived", result_queue.size());
            fault_count++;
        end

        $display("covered %0d words: %0d sends (%0d refused on a full fifo),",
                 words_made, op_seen[OP_SEND], full_drops);
        $display("  %0d receives (%0d on empty), %0d sync writes, %0d control writes,",
                 op_seen[OP_RECV], empty_pops, op_seen[OP_WR_SYNC], op_seen[OP_WR_CTRL]);
        $display("  %0d reads, %0d spare ops, %0d with irqs",
                 op_seen[OP_RD_SYNC] + op_seen[OP_RD_CTRL],
                 op_seen[OP_SPARE_6] + op_seen[OP_SPARE_7], irq_words);
        if (fault_count == 0) begin
            $display("dual_cpu_sync_and_fifo_mailbox test passed");
        end else begin
            $display("dual_cpu_sync_and_fifo_mailbox test failed");
        end
        $finish;
    end

endmodule
